[sv/yagbd_pkg.sv]
package yagbd_pkg;

   localparam int INPUT_SIZE_DEF        = 640;
   localparam int NUM_SCALES_DEF        = 3;
   localparam int ANCHORS_PER_SCALE_DEF = 3;

   localparam int GRID_W   = 7;
   localparam int ANCHOR_W = 9;
   localparam int FINE_W   = 49;
   localparam int MUL_A_W  = 48;
   localparam int MUL_B_W  = 16;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 136;

   localparam logic [15:0] OBJ_THR_RESET   = 16'd32768;
   localparam logic [15:0] SCORE_THR_RESET = 16'd16384;
   localparam logic [15:0] RATIO_RESET     = 16'd4096;

   typedef enum logic [2:0] {
      CSR_OBJ_THR   = 3'd0,
      CSR_SCORE_THR = 3'd1,
      CSR_PAD_LEFT  = 3'd2,
      CSR_PAD_TOP   = 3'd3,
      CSR_RATIO_X   = 3'd4,
      CSR_RATIO_Y   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] objectness_threshold;
      logic [15:0] score_threshold;
      logic [9:0]  pad_left;
      logic [9:0]  pad_top;
      logic [15:0] ratio_x;
      logic [15:0] ratio_y;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        scale;
      logic [1:0]        anchor;
      logic [GRID_W-1:0] row;
      logic [GRID_W-1:0] col;
   } walk_pos_type;

   typedef struct packed {
      logic clear;
      logic step;
   } walk_ctl_type;

   typedef struct packed {
      logic               go;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        net_box_width;
      logic [15:0]        net_box_height;
      logic signed [13:0] left_edge;
      logic signed [13:0] top_edge;
      logic [12:0]        image_box_width;
      logic [12:0]        image_box_height;
      logic [15:0]        confidence;
   } result_type;

   localparam logic [ANCHOR_W-1:0] ANCHOR_ROM [18] = '{
      9'd10,  9'd13,  9'd16,  9'd30,  9'd33,  9'd23,
      9'd30,  9'd61,  9'd62,  9'd45,  9'd59,  9'd119,
      9'd116, 9'd90,  9'd156, 9'd198, 9'd373, 9'd326
   };

   function automatic logic [ANCHOR_W-1:0] anchor_size(input logic [1:0] scale,
                                                      input logic [1:0] anchor,
                                                      input logic       is_h);
      logic [4:0] idx;
      idx = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0} + {2'b00, anchor, 1'b0}
            + {4'h0, is_h};
      if (idx >= 5'd18) begin
         idx = idx - 5'd18;
      end
      return ANCHOR_ROM[idx];
   endfunction

endpackage

[sv/yagbd_mul.sv]
module yagbd_mul (
   input  logic                           clock,
   input  yagbd_pkg::mul_req_type         req,
   output logic [yagbd_pkg::MUL_P_W-1:0]  prod
);
   import yagbd_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = req.a * req.b;

   always_ff @(posedge clock) begin
      if (req.go) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[sv/yagbd_walk.sv]
module yagbd_walk #(
   parameter int INPUT_SIZE        = yagbd_pkg::INPUT_SIZE_DEF,
   parameter int NUM_SCALES        = yagbd_pkg::NUM_SCALES_DEF,
   parameter int ANCHORS_PER_SCALE = yagbd_pkg::ANCHORS_PER_SCALE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  yagbd_pkg::walk_ctl_type ctl,
   output yagbd_pkg::walk_pos_type pos
);
   import yagbd_pkg::*;

   localparam logic [GRID_W:0] GRID0 = (GRID_W+1)'((INPUT_SIZE + 7) / 8);
   localparam logic [GRID_W:0] GRID1 = (GRID_W+1)'((INPUT_SIZE + 15) / 16);
   localparam logic [GRID_W:0] GRID2 = (GRID_W+1)'((INPUT_SIZE + 31) / 32);
   localparam logic [GRID_W:0] GRID3 = (GRID_W+1)'((INPUT_SIZE + 63) / 64);
   localparam logic [1:0] LAST_ANCHOR = 2'(ANCHORS_PER_SCALE - 1);
   localparam logic [1:0] LAST_SCALE  = 2'(NUM_SCALES - 1);

   walk_pos_type    pos_ff;
   walk_pos_type    pos_in;
   logic [GRID_W:0] grid_n;
   logic            last_col;
   logic            last_row;

   always_comb begin
      unique case (pos_ff.scale)
         2'd0:    grid_n = GRID0;
         2'd1:    grid_n = GRID1;
         2'd2:    grid_n = GRID2;
         default: grid_n = GRID3;
      endcase
   end

   assign last_col = ({1'b0, pos_ff.col} + 1'b1) >= grid_n;
   assign last_row = ({1'b0, pos_ff.row} + 1'b1) >= grid_n;

   always_comb begin
      pos_in = pos_ff;
      if (ctl.clear) begin
         pos_in = '0;
      end else if (ctl.step) begin
         if (!last_col) begin
            pos_in.col = pos_ff.col + 1'b1;
         end else begin
            pos_in.col = '0;
            if (!last_row) begin
               pos_in.row = pos_ff.row + 1'b1;
            end else begin
               pos_in.row = '0;
               if (pos_ff.anchor != LAST_ANCHOR) begin
                  pos_in.anchor = pos_ff.anchor + 1'b1;
               end else begin
                  pos_in.anchor = '0;
                  pos_in.scale  = (pos_ff.scale != LAST_SCALE) ? pos_ff.scale + 1'b1 : 2'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

[sv/yagbd_core.sv]
module yagbd_core #(
   parameter int INPUT_SIZE        = yagbd_pkg::INPUT_SIZE_DEF,
   parameter int NUM_SCALES        = yagbd_pkg::NUM_SCALES_DEF,
   parameter int ANCHORS_PER_SCALE = yagbd_pkg::ANCHORS_PER_SCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [yagbd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  yagbd_pkg::cfg_type                  cfg,
   input  logic                                out_free,
   output logic                                out_load,
   output yagbd_pkg::result_type               result
);
   import yagbd_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_CONF = 13'b0000000000010,
      ST_W2   = 13'b0000000000100,
      ST_H2   = 13'b0000000001000,
      ST_FW   = 13'b0000000010000,
      ST_FH   = 13'b0000000100000,
      ST_DX   = 13'b0000001000000,
      ST_MX   = 13'b0000010000000,
      ST_MY   = 13'b0000100000000,
      ST_IW   = 13'b0001000000000,
      ST_IH   = 13'b0010000000000,
      ST_DONE = 13'b0100000000000,
      ST_SPARE_UNUSED_NEVER = 13'b1000000000000
   } state_type;

   function automatic logic [15:0] center_q(input logic signed [24:0] ax,
                                            input logic [1:0]         scale);
      logic [24:0] neg;
      logic [23:0] mag;
      logic [23:0] q;
      logic [3:0]  sh;
      neg = 25'(-ax);
      mag = ax[24] ? neg[23:0] : ax[23:0];
      sh  = 4'd9 - {2'b00, scale};
      q   = mag >> sh;
      if (!ax[24]) begin
         return (q > 24'd32767) ? 16'h7FFF : q[15:0];
      end
      return (q > 24'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
   endfunction

   function automatic logic [13:0] edge_q(input logic neg, input logic [19:0] mag);
      if (!neg) begin
         return (mag > 20'd8191) ? 14'h1FFF : mag[13:0];
      end
      return (mag > 20'd8192) ? 14'h2000 : 14'(14'd0 - mag[13:0]);
   endfunction

   function automatic logic [12:0] img_q(input logic [19:0] mag);
      return (mag > 20'd8191) ? 13'h1FFF : mag[12:0];
   endfunction

   state_type state_ff;
   state_type state_in;

   logic [15:0] px_ff, py_ff, pw_ff, ph_ff, obj_ff, cls_ff;
   logic signed [24:0] ax_ff, ay_ff, ax_in, ay_in;
   logic signed [FINE_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [FINE_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [FINE_W-1:0] dx_neg, dy_neg;
   logic [MUL_A_W-1:0] dx_mag, dy_mag;
   logic [15:0] conf_ff, cen_x_ff, cen_y_ff;
   logic [31:0] wq_ff, hq_ff;
   logic [42:0] fw_ff, fh_ff;
   logic [13:0] left_ff, top_ff;
   logic [12:0] imgw_ff;
   logic        keep_in;
   logic [ANCHOR_W-1:0] aw, ah;

   walk_pos_type       pos;
   walk_ctl_type       walk_ctl;
   mul_req_type        mul_req;
   logic [MUL_P_W-1:0] prod;

   yagbd_walk #(
      .INPUT_SIZE        (INPUT_SIZE),
      .NUM_SCALES        (NUM_SCALES),
      .ANCHORS_PER_SCALE (ANCHORS_PER_SCALE)
   ) u_walk (
      .clock (clock),
      .reset (reset),
      .ctl   (walk_ctl),
      .pos   (pos)
   );

   yagbd_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   assign aw = anchor_size(pos.scale, pos.anchor, 1'b0);
   assign ah = anchor_size(pos.scale, pos.anchor, 1'b1);

   assign ax_in = $signed({2'b00, pos.col, 16'h0000}) + $signed({8'h00, px_ff, 1'b0})
                  - 25'sd32768;
   assign ay_in = $signed({2'b00, pos.row, 16'h0000}) + $signed({8'h00, py_ff, 1'b0})
                  - 25'sd32768;

   assign cx_in = ($signed({{24{ax_ff[24]}}, ax_ff}) <<< (5'(pos.scale) + 5'd19))
                  - $signed({7'h00, cfg.pad_left, 32'h0});
   assign cy_in = ($signed({{24{ay_ff[24]}}, ay_ff}) <<< (5'(pos.scale) + 5'd19))
                  - $signed({7'h00, cfg.pad_top, 32'h0});

   assign dx_in = cx_ff - $signed({7'h00, fw_ff[42:1]});
   assign dy_in = cy_ff - $signed({7'h00, fh_ff[42:1]});

   assign dx_neg = FINE_W'(-dx_ff);
   assign dy_neg = FINE_W'(-dy_ff);
   assign dx_mag = dx_ff[FINE_W-1] ? dx_neg[MUL_A_W-1:0] : dx_ff[MUL_A_W-1:0];
   assign dy_mag = dy_ff[FINE_W-1] ? dy_neg[MUL_A_W-1:0] : dy_ff[MUL_A_W-1:0];

   assign keep_in = (obj_ff > cfg.objectness_threshold)
                    && (prod[31:0] > {cfg.score_threshold, 16'h0000});

   always_comb begin
      state_in = state_ff;
      walk_ctl = '0;
      mul_req  = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               walk_ctl.clear = req_tuser;
               state_in       = ST_CONF;
            end
         end
         ST_CONF: begin
            mul_req  = '{go: 1'b1, a: {32'h0, obj_ff}, b: cls_ff};
            state_in = ST_W2;
         end
         ST_W2: begin
            if (keep_in) begin
               mul_req  = '{go: 1'b1, a: {32'h0, pw_ff}, b: pw_ff};
               state_in = ST_H2;
            end else begin
               walk_ctl.step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_H2: begin
            mul_req  = '{go: 1'b1, a: {32'h0, ph_ff}, b: ph_ff};
            state_in = ST_FW;
         end
         ST_FW: begin
            mul_req  = '{go: 1'b1, a: {16'h0, wq_ff}, b: {7'h00, aw}};
            state_in = ST_FH;
         end
         ST_FH: begin
            mul_req  = '{go: 1'b1, a: {16'h0, hq_ff}, b: {7'h00, ah}};
            state_in = ST_DX;
         end
         ST_DX: begin
            state_in = ST_MX;
         end
         ST_MX: begin
            mul_req  = '{go: 1'b1, a: dx_mag, b: cfg.ratio_x};
            state_in = ST_MY;
         end
         ST_MY: begin
            mul_req  = '{go: 1'b1, a: dy_mag, b: cfg.ratio_y};
            state_in = ST_IW;
         end
         ST_IW: begin
            mul_req  = '{go: 1'b1, a: {5'h00, fw_ff}, b: cfg.ratio_x};
            state_in = ST_IH;
         end
         ST_IH: begin
            mul_req  = '{go: 1'b1, a: {5'h00, fh_ff}, b: cfg.ratio_y};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_load      = 1'b1;
               walk_ctl.step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         px_ff  <= req_tdata[15:0];
         py_ff  <= req_tdata[31:16];
         pw_ff  <= req_tdata[47:32];
         ph_ff  <= req_tdata[63:48];
         obj_ff <= req_tdata[79:64];
         cls_ff <= req_tdata[95:80];
      end
      if (state_ff == ST_CONF) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
      if (state_ff == ST_W2) begin
         conf_ff <= prod[31:16];
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
      end
      if (state_ff == ST_H2) begin
         wq_ff    <= prod[31:0];
         cen_x_ff <= center_q(ax_ff, pos.scale);
         cen_y_ff <= center_q(ay_ff, pos.scale);
      end
      if (state_ff == ST_FW) begin
         hq_ff <= prod[31:0];
      end
      if (state_ff == ST_FH) begin
         fw_ff <= {prod[40:0], 2'b00};
      end
      if (state_ff == ST_DX) begin
         fh_ff <= {prod[40:0], 2'b00};
         dx_ff <= dx_in;
      end
      if (state_ff == ST_MX) begin
         dy_ff <= dy_in;
      end
      if (state_ff == ST_MY) begin
         left_ff <= edge_q(dx_ff[FINE_W-1], prod[63:44]);
      end
      if (state_ff == ST_IW) begin
         top_ff <= edge_q(dy_ff[FINE_W-1], prod[63:44]);
      end
      if (state_ff == ST_IH) begin
         imgw_ff <= img_q(prod[63:44]);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      result.center_x         = cen_x_ff;
      result.center_y         = cen_y_ff;
      result.net_box_width    = {1'b0, fw_ff[42:28]};
      result.net_box_height   = {1'b0, fh_ff[42:28]};
      result.left_edge        = left_ff;
      result.top_edge         = top_ff;
      result.image_box_width  = imgw_ff;
      result.image_box_height = img_q(prod[63:44]);
      result.confidence       = conf_ff;
   end

endmodule

[sv/yolo_anchor_grid_box_decode.sv]
// Channel  Dir  Handshake              Word
// req      in   req_tvalid/req_tready  offsets, sizes, scores; tuser = frame_start
// rsp      out  rsp_tvalid/rsp_tready  centers, sizes, edges, image sizes, confidence
// csr      in   csr_we                 register index and write data
//
// A kept row holds the sequencer from its accept until its result is loaded, then raises
// rsp_tvalid; a rejected row holds it through the threshold check and returns no word.
// One shared 48x16 multiplier with a registered product is stepped through nine products.
// Synchronous active-high reset clears the sequencer, grid walk, output valid and
// registers to their defaults. A result waiting on rsp does not block the next
// accept; the sequencer holds its final step until the output register is free.
module yolo_anchor_grid_box_decode #(
   parameter int INPUT_SIZE        = yagbd_pkg::INPUT_SIZE_DEF,
   parameter int NUM_SCALES        = yagbd_pkg::NUM_SCALES_DEF,
   parameter int ANCHORS_PER_SCALE = yagbd_pkg::ANCHORS_PER_SCALE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // offset_x, offset_y, raw_width, raw_height, objectness, class_score
   input  logic [95:0]  req_tdata,
   // frame_start
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x, center_y, net_box_width, net_box_height, left_edge, top_edge,
   // image_box_width, image_box_height, confidence, zero fill
   output logic [135:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import yagbd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic       out_free;
   logic       out_load;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OBJ_THR:   cfg_in.objectness_threshold = csr_wdata;
            CSR_SCORE_THR: cfg_in.score_threshold      = csr_wdata;
            CSR_PAD_LEFT:  cfg_in.pad_left             = csr_wdata[9:0];
            CSR_PAD_TOP:   cfg_in.pad_top              = csr_wdata[9:0];
            CSR_RATIO_X:   cfg_in.ratio_x              = csr_wdata;
            CSR_RATIO_Y:   cfg_in.ratio_y              = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.objectness_threshold <= OBJ_THR_RESET;
         cfg_ff.score_threshold      <= SCORE_THR_RESET;
         cfg_ff.pad_left             <= '0;
         cfg_ff.pad_top              <= '0;
         cfg_ff.ratio_x              <= RATIO_RESET;
         cfg_ff.ratio_y              <= RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   yagbd_core #(
      .INPUT_SIZE        (INPUT_SIZE),
      .NUM_SCALES        (NUM_SCALES),
      .ANCHORS_PER_SCALE (ANCHORS_PER_SCALE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .out_load   (out_load),
      .result     (result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {2'b00,
                         result.confidence,
                         result.image_box_height,
                         result.image_box_width,
                         result.top_edge,
                         result.left_edge,
                         result.net_box_height,
                         result.net_box_width,
                         result.center_y,
                         result.center_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/yagbd_check.sv]
module yagbd_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata
);

   // an accepted word keeps the sequencer busy through its CONF and W2 states
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("req_tready returned too early after accept");

   // the final step loads the result and frees the input in the same cycle
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result issued while sequencer still busy");

   a_reset_state: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid && req_tready)
      else $error("ports not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

endmodule

bind yolo_anchor_grid_box_decode yagbd_check u_yagbd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/yolo_anchor_grid_box_decode_test.sv]
`timescale 1ns / 1ps

module yolo_anchor_grid_box_decode_test;
   import yagbd_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int NET_SHIFT     = 28;
   localparam int EDGE_SHIFT    = 44;
   localparam int WALK_ROWS     = 120;
   localparam int WALK_RESTART  = 100;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [15:0] offset_x;
      logic [15:0] offset_y;
      logic [15:0] raw_width;
      logic [15:0] raw_height;
      logic [15:0] objectness;
      logic [15:0] class_score;
      logic        frame_start;
   } pred_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [95:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;
   wire          req_tready;
   wire          rsp_tvalid;
   wire  [135:0] rsp_tdata;

   cfg_type      cfg;
   logic [1:0]   walk_scale;
   logic [1:0]   walk_anchor;
   logic [6:0]   walk_row;
   logic [6:0]   walk_col;
   result_type   expected_boxes[$];
   result_type   seen_box;
   result_type   due_box;
   int           errors = 0;
   int           rows_sent = 0;
   int           boxes_checked = 0;
   int           reg_writes = 0;
   bit           idle_on = 1'b1;
   int           gap_odds = 4;
   int           stall_left = 0;

   yolo_anchor_grid_box_decode dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int grid_cells(input logic [1:0] s);
      int stride;
      stride = 8 << s;
      return (INPUT_SIZE_DEF + stride - 1) / stride;
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom);
   endfunction

   task automatic predict_row(input pred_row_type r);
      longint px, py, pw, ph, obj, cls, prod, obj_thr, score_thr;
      longint stride, aw, ah, col, row, cx, cy, fw, fh, lx, ty;
      longint padl, padt, rx, ry;
      logic [4:0] rom_idx;
      result_type box;
      int n;
      if (r.frame_start) begin
         walk_scale = '0;
         walk_anchor = '0;
         walk_row = '0;
         walk_col = '0;
      end
      px = longint'(r.offset_x);
      py = longint'(r.offset_y);
      pw = longint'(r.raw_width);
      ph = longint'(r.raw_height);
      obj = longint'(r.objectness);
      cls = longint'(r.class_score);
      obj_thr = longint'(cfg.objectness_threshold);
      score_thr = longint'(cfg.score_threshold);
      prod = obj * cls;
      if (obj > obj_thr && prod > (score_thr << 16)) begin
         stride = 64'sd8 << walk_scale;
         rom_idx = 5'(int'(walk_scale) * 6 + int'(walk_anchor) * 2);
         aw = longint'(ANCHOR_ROM[rom_idx]);
         ah = longint'(ANCHOR_ROM[rom_idx + 5'd1]);
         col = longint'(walk_col);
         row = longint'(walk_row);
         // positions and sizes in units of 2^-32 pixel
         cx = (2 * px - 32768 + col * 65536) * stride * 65536;
         cy = (2 * py - 32768 + row * 65536) * stride * 65536;
         fw = (2 * pw) * (2 * pw) * aw;
         fh = (2 * ph) * (2 * ph) * ah;
         padl = longint'(cfg.pad_left);
         padt = longint'(cfg.pad_top);
         rx = longint'(cfg.ratio_x);
         ry = longint'(cfg.ratio_y);
         lx = (cx - padl * (64'sd1 <<< 32) - fw / 2) * rx;
         ty = (cy - padt * (64'sd1 <<< 32) - fh / 2) * ry;
         box.center_x = 16'(clip(cx / (64'sd1 <<< NET_SHIFT), -32768, 32767));
         box.center_y = 16'(clip(cy / (64'sd1 <<< NET_SHIFT), -32768, 32767));
         box.net_box_width = 16'(clip(fw >>> NET_SHIFT, 0, 65535));
         box.net_box_height = 16'(clip(fh >>> NET_SHIFT, 0, 65535));
         box.left_edge = 14'(clip(lx / (64'sd1 <<< EDGE_SHIFT), -8192, 8191));
         box.top_edge = 14'(clip(ty / (64'sd1 <<< EDGE_SHIFT), -8192, 8191));
         box.image_box_width = 13'(clip((fw * rx) >>> EDGE_SHIFT, 0, 8191));
         box.image_box_height = 13'(clip((fh * ry) >>> EDGE_SHIFT, 0, 8191));
         box.confidence = 16'(prod >>> 16);
         expected_boxes.insert(expected_boxes.size(), box);
      end
      n = grid_cells(walk_scale);
      if (int'(walk_col) + 1 < n) begin
         walk_col++;
      end else begin
         walk_col = '0;
         if (int'(walk_row) + 1 < n) begin
            walk_row++;
         end else begin
            walk_row = '0;
            if (int'(walk_anchor) + 1 < ANCHORS_PER_SCALE_DEF) begin
               walk_anchor++;
            end else begin
               walk_anchor = '0;
               if (int'(walk_scale) + 1 < NUM_SCALES_DEF) begin
                  walk_scale++;
               end else begin
                  walk_scale = '0;
               end
            end
         end
      end
   endtask

   task automatic send_row(input pred_row_type r);
      if (idle_on && $urandom_range(1, gap_odds) == 1) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {r.class_score, r.objectness, r.raw_height, r.raw_width,
                   r.offset_y, r.offset_x};
      req_tuser = r.frame_start;
      do @(posedge clock); while (!req_tready);
      predict_row(r);
      rows_sent++;
   endtask

   task automatic wait_idle();
      int waited;
      @(negedge clock);
      req_tvalid = 1'b0;
      waited = 0;
      while (expected_boxes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_boxes.size() != 0) begin
         report_mismatch($sformatf("%0d boxes never arrived", expected_boxes.size()));
         expected_boxes.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_OBJ_THR:   cfg.objectness_threshold = val;
         CSR_SCORE_THR: cfg.score_threshold = val;
         CSR_PAD_LEFT:  cfg.pad_left = val[9:0];
         CSR_PAD_TOP:   cfg.pad_top = val[9:0];
         CSR_RATIO_X:   cfg.ratio_x = val;
         CSR_RATIO_Y:   cfg.ratio_y = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
      reg_writes++;
   endtask

   task automatic set_config(input logic [15:0] obj_thr, input logic [15:0] score_thr,
                             input logic [15:0] padl, input logic [15:0] padt,
                             input logic [15:0] rx, input logic [15:0] ry);
      wait_idle();
      write_reg(CSR_OBJ_THR, obj_thr);
      write_reg(CSR_SCORE_THR, score_thr);
      write_reg(CSR_PAD_LEFT, padl);
      write_reg(CSR_PAD_TOP, padt);
      write_reg(CSR_RATIO_X, rx);
      write_reg(CSR_RATIO_Y, ry);
   endtask

   function automatic pred_row_type make_row(input logic [15:0] px, input logic [15:0] py,
                                             input logic [15:0] pw, input logic [15:0] ph,
                                             input logic [15:0] obj, input logic [15:0] cls,
                                             input logic fs);
      pred_row_type r;
      r.offset_x = px;
      r.offset_y = py;
      r.raw_width = pw;
      r.raw_height = ph;
      r.objectness = obj;
      r.class_score = cls;
      r.frame_start = fs;
      return r;
   endfunction

   function automatic pred_row_type noise_row();
      return make_row(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), $urandom_range(0, 49) == 0);
   endfunction

   // biased toward passing both thresholds
   function automatic pred_row_type likely_kept_row();
      pred_row_type r;
      r = noise_row();
      if (cfg.objectness_threshold != 16'hFFFF) begin
         r.objectness = 16'($urandom_range(int'(cfg.objectness_threshold) + 1, 65535));
      end
      r.class_score = 16'($urandom_range(int'(cfg.score_threshold), 65535));
      return r;
   endfunction

   function automatic logic [15:0] pick_extreme_or_random();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return rand_word();
      endcase
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (idle_on && $urandom_range(1, 6) == 1) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_box.center_x = rsp_tdata[15:0];
         seen_box.center_y = rsp_tdata[31:16];
         seen_box.net_box_width = rsp_tdata[47:32];
         seen_box.net_box_height = rsp_tdata[63:48];
         seen_box.left_edge = rsp_tdata[77:64];
         seen_box.top_edge = rsp_tdata[91:78];
         seen_box.image_box_width = rsp_tdata[104:92];
         seen_box.image_box_height = rsp_tdata[117:105];
         seen_box.confidence = rsp_tdata[133:118];
         if (expected_boxes.size() == 0) begin
            report_mismatch("box word with none pending");
         end else begin
            due_box = expected_boxes.pop_front();
            if (seen_box.center_x !== due_box.center_x)
               report_mismatch($sformatf("center_x got %0d want %0d",
                                         seen_box.center_x, due_box.center_x));
            if (seen_box.center_y !== due_box.center_y)
               report_mismatch($sformatf("center_y got %0d want %0d",
                                         seen_box.center_y, due_box.center_y));
            if (seen_box.net_box_width !== due_box.net_box_width)
               report_mismatch($sformatf("net_box_width got %0d want %0d",
                                         seen_box.net_box_width, due_box.net_box_width));
            if (seen_box.net_box_height !== due_box.net_box_height)
               report_mismatch($sformatf("net_box_height got %0d want %0d",
                                         seen_box.net_box_height, due_box.net_box_height));
            if (seen_box.left_edge !== due_box.left_edge)
               report_mismatch($sformatf("left_edge got %0d want %0d",
                                         seen_box.left_edge, due_box.left_edge));
            if (seen_box.top_edge !== due_box.top_edge)
               report_mismatch($sformatf("top_edge got %0d want %0d",
                                         seen_box.top_edge, due_box.top_edge));
            if (seen_box.image_box_width !== due_box.image_box_width)
               report_mismatch($sformatf("image_box_width got %0d want %0d",
                                         seen_box.image_box_width, due_box.image_box_width));
            if (seen_box.image_box_height !== due_box.image_box_height)
               report_mismatch($sformatf("image_box_height got %0d want %0d",
                                         seen_box.image_box_height, due_box.image_box_height));
            if (seen_box.confidence !== due_box.confidence)
               report_mismatch($sformatf("confidence got %0d want %0d",
                                         seen_box.confidence, due_box.confidence));
         end
         boxes_checked++;
      end
   end

   task automatic test_default_setting();
      send_row(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_row(make_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_row(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
      // objectness equal to its threshold
      send_row(make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0));
      // product one below, then just above, the score threshold
      send_row(make_row(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h8001, 16'h7FFF, 1'b0));
      send_row(make_row(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h8001, 16'h8000, 1'b0));
      send_row(make_row(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0));
      send_row(make_row(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hD555, 16'hAAAA, 1'b0));
      // zero ratio clears the image-space fields
      set_config(16'h8000, 16'h4000, 16'd0, 16'd0, 16'h0000, 16'h0000);
      send_row(make_row(16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
      send_row(make_row(16'h0000, 16'h0000, 16'h8000, 16'h0100, 16'hF000, 16'hF000, 1'b1));
      // full padding with the largest ratio drives the edges to saturation
      set_config(16'h8000, 16'h4000, 16'd640, 16'd640, 16'hFFFF, 16'hFFFF);
      send_row(make_row(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
      send_row(make_row(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
   endtask

   task automatic test_thresholds();
      set_config(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd4096, 16'd4096);
      send_row(make_row(16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h0001, 16'h0001, 1'b0));
      send_row(make_row(16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h0000, 16'hFFFF, 1'b0));
      send_row(make_row(16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'hFFFF, 16'h0000, 1'b0));
      repeat (50) send_row(noise_row());
      // product equal to the score threshold is rejected
      set_config(16'h0000, 16'h4000, 16'd0, 16'd0, 16'd4096, 16'd4096);
      send_row(make_row(16'h7777, 16'h8888, 16'h9999, 16'h6666, 16'h8000, 16'h8000, 1'b0));
      send_row(make_row(16'h7777, 16'h8888, 16'h9999, 16'h6666, 16'h8000, 16'h8001, 1'b0));
      set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd4096, 16'd4096);
      repeat (40) send_row(noise_row());
      repeat (3) begin
         set_config(rand_word(), 16'($urandom_range(0, 16'h7FFF)),
                    16'($urandom_range(0, 640)), 16'($urandom_range(0, 640)),
                    rand_word(), rand_word());
         repeat (60) send_row($urandom_range(0, 3) == 0 ? noise_row() : likely_kept_row());
      end
   endtask

   task automatic test_letterbox_mapping();
      pred_row_type r;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_config(16'h4000, 16'h1000, 16'd640, 16'd0, 16'hFFFF, 16'h0000);
            1: set_config(16'h4000, 16'h1000, 16'd0, 16'd640, 16'h0000, 16'hFFFF);
            default: set_config(16'h4000, 16'h1000, rand_word(), rand_word(),
                                pick_extreme_or_random(), pick_extreme_or_random());
         endcase
         repeat (80) begin
            r = $urandom_range(0, 3) == 0 ? noise_row() : likely_kept_row();
            r.frame_start = 1'b0;
            send_row(r);
         end
      end
   endtask

   task automatic test_grid_walk();
      pred_row_type r;
      int n;
      bit corner;
      set_config(16'h8000, 16'h4000, 16'd0, 16'd0, 16'hFFFF, 16'h3000);
      gap_odds = 200;
      for (int i = 0; i < WALK_ROWS; i++) begin
         n = grid_cells(walk_scale);
         corner = (int'(walk_col) == 0 || int'(walk_col) == n - 1)
                  && (int'(walk_row) == 0 || int'(walk_row) == n - 1);
         if (i == 0 || i == WALK_RESTART || corner || $urandom_range(0, 119) == 0) begin
            r = likely_kept_row();
         end else begin
            r = noise_row();
            r.objectness = 16'($urandom_range(0, int'(cfg.objectness_threshold)));
         end
         r.frame_start = (i == 0 || i == WALK_RESTART);
         send_row(r);
      end
      gap_odds = 4;
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) begin
            wait_idle();
            idle_on = 1'b0;
         end
         set_config(pick_extreme_or_random() >> $urandom_range(0, 2),
                    pick_extreme_or_random() >> $urandom_range(0, 3),
                    rand_word(), rand_word(), pick_extreme_or_random(),
                    pick_extreme_or_random());
         write_reg(CSR_SPARE_LO, rand_word());
         write_reg(CSR_SPARE_HI, rand_word());
         repeat (phase == 4 ? 120 : 80) begin
            send_row($urandom_range(0, 9) < 3 ? noise_row() : likely_kept_row());
         end
      end
   endtask

   initial begin
      cfg.objectness_threshold = OBJ_THR_RESET;
      cfg.score_threshold = SCORE_THR_RESET;
      cfg.pad_left = '0;
      cfg.pad_top = '0;
      cfg.ratio_x = RATIO_RESET;
      cfg.ratio_y = RATIO_RESET;
      walk_scale = '0;
      walk_anchor = '0;
      walk_row = '0;
      walk_col = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_setting();
      test_thresholds();
      test_letterbox_mapping();
      test_grid_walk();
      test_random_settings();
      wait_idle();
      $display("covered %0d rows, %0d boxes checked, %0d register writes", rows_sent,
               boxes_checked, reg_writes);
      $display("thresholds and ties, padding, ratios incl. zero and max, walk start and restarts");
      if (errors == 0) begin
         $display("PASS yolo_anchor_grid_box_decode");
      end else begin
         $display("FAIL yolo_anchor_grid_box_decode");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAIL yolo_anchor_grid_box_decode");
      $finish;
   end

endmodule
